[hdl/gdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day-count converter: shared package
// Field types, calendar tables, derived constants and the result struct.
// ----------------------------------------------------------------------------
package gdc_pkg;

	// Calendar span
	localparam int FIRST_YEAR = 1970;
	localparam int LAST_YEAR  = 9999;

	localparam int DAYS_YEAR = 365;
	localparam int DAYS_LEAP = 366;

	// Internal count and product widths
	localparam int CW = 24;
	localparam int PW = 2 * CW;
	localparam int YW = 15;

	typedef logic [CW-1:0] cnt_t;
	typedef logic [PW-1:0] prod_t;
	typedef logic [YW-1:0] year_t;
	typedef logic [4:0]    day_t;
	typedef logic [3:0]    month_t;
	typedef logic [13:0]   year_in_t;
	typedef logic [21:0]   count_in_t;
	typedef logic [2:0]    wday_t;
	typedef logic [8:0]    doy_t;

	// Command codes
	localparam logic CMD_DATE  = 1'b0;
	localparam logic CMD_COUNT = 1'b1;

	// Leap days from year 1 to the year before the span, and to its last year
	localparam int FIRST_LEAPS = (FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100
		+ (FIRST_YEAR - 1) / 400;
	localparam int LAST_LEAPS  = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400;
	localparam int SPAN_DAYS_I = (LAST_YEAR < FIRST_YEAR) ? 0 :
		(LAST_YEAR - FIRST_YEAR + 1) * DAYS_YEAR + LAST_LEAPS - FIRST_LEAPS;
	localparam cnt_t SPAN_DAYS = CW'(SPAN_DAYS_I);

	// Reciprocals for constant division
	localparam cnt_t RECIP_100  = CW'((1 << 19) / 100 + 1);
	localparam cnt_t RECIP_7    = CW'((1 << 26) / 7 + 1);
	localparam logic [63:0] RECIP_YEAR_W = ((64'd400 << 32) / 64'd146097) + 64'd1;
	localparam cnt_t RECIP_YEAR = RECIP_YEAR_W[CW-1:0];

	localparam day_t MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
	localparam doy_t CUM_DAYS [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

	// Shared multiplier operands
	typedef struct packed {
		cnt_t a;
		cnt_t b;
	} mul_req_t;

	// Finished result handed to the output stage
	typedef struct packed {
		logic      valid;
		count_in_t days_out;
		day_t      day_out;
		month_t    month_out;
		year_in_t  year_out;
		wday_t     weekday_out;
		logic      date_valid;
	} res_t;

	function automatic day_t month_len(input month_t m, input logic leap);
		day_t len;
		len = '0;
		if (m >= 4'd1 && m <= 4'd12) begin
			len = MONTH_LEN[m - 4'd1];
			if (m == 4'd2 && leap) begin
				len = 5'd29;
			end
		end
		return len;
	endfunction

	function automatic doy_t cum_days(input month_t m, input logic leap);
		doy_t cum;
		cum = '0;
		if (m >= 4'd1 && m <= 4'd12) begin
			cum = CUM_DAYS[m - 4'd1];
			if (leap && m > 4'd2) begin
				cum = cum + 9'd1;
			end
		end
		return cum;
	endfunction

	// Month holding a day of the year: count month starts at or below it
	function automatic month_t month_of(input doy_t rem, input logic leap);
		month_t m;
		m = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (rem >= cum_days(4'(k), leap)) begin
				m = m + 4'd1;
			end
		end
		return m;
	endfunction

endpackage

[hdl/gdc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day-count converter: input channel
// Valid/ready channel carrying one conversion request.
// ----------------------------------------------------------------------------
interface gdc_in_if import gdc_pkg::*; ;
	logic      valid;
	logic      ready;
	logic      command;
	day_t      day_in;
	month_t    month_in;
	year_in_t  year_in;
	count_in_t day_count_in;

	modport source (
		output valid, command, day_in, month_in, year_in, day_count_in,
		input  ready
	);

	modport sink (
		input  valid, command, day_in, month_in, year_in, day_count_in,
		output ready
	);
endinterface

[hdl/gdc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day-count converter: result channel
// Valid/ready channel carrying one converted date.
// ----------------------------------------------------------------------------
interface gdc_out_if import gdc_pkg::*; ;
	logic      valid;
	logic      ready;
	count_in_t days_out;
	day_t      day_out;
	month_t    month_out;
	year_in_t  year_out;
	wday_t     weekday_out;
	logic      date_valid;

	modport source (
		output valid, days_out, day_out, month_out, year_out, weekday_out, date_valid,
		input  ready
	);

	modport sink (
		input  valid, days_out, day_out, month_out, year_out, weekday_out, date_valid,
		output ready
	);
endinterface

[hdl/gdc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day-count converter: shared multiplier
// One registered unsigned multiply, shared by the sequencer's multiplying steps.
// ----------------------------------------------------------------------------
module gdc_mul import gdc_pkg::*; (
	input  logic     clk,
	input  mul_req_t req,
	output prod_t    p
);

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= PW'(req.a) * PW'(req.b);
	end

	assign p = p_q;

endmodule

[hdl/gdc_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day-count converter: sequencer
// Steps one request through the year estimate, leap test, date check, day-before-year
// sums, year correction, month search and weekday, driving the shared multiplier.
// ----------------------------------------------------------------------------
module gdc_seq import gdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	gdc_in_if.sink   item,
	output res_t     res,
	input  logic     res_ready,
	output mul_req_t mul_req,
	input  prod_t    mul_p
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EST  = 4'd1;
	localparam logic [3:0] S_EST2 = 4'd2;
	localparam logic [3:0] S_L1   = 4'd3;
	localparam logic [3:0] S_L2   = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_D1   = 4'd6;
	localparam logic [3:0] S_D2   = 4'd7;
	localparam logic [3:0] S_D3   = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;
	localparam logic [3:0] S_MON  = 4'd10;
	localparam logic [3:0] S_DAY  = 4'd11;
	localparam logic [3:0] S_W1   = 4'd12;
	localparam logic [3:0] S_W2   = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0]  state_q, state_d;
	logic        cmd_q;
	day_t        day_q;
	month_t      month_q;
	year_t       year_q;
	cnt_t        count_q;
	logic        leap_q;
	logic        valid_q;
	logic [12:0] leaps_q;
	cnt_t        dby_q;
	doy_t        rem_q;
	wday_t       wday_q;

	logic        acc;
	logic        count_ok;
	year_t       year_m1;
	logic [12:0] q4_c;
	logic [7:0]  q100_c;
	logic [12:0] leaps_c;
	logic [8:0]  qy_c;
	year_t       hund_c;
	logic        leap_c;
	logic        chk_ok;
	cnt_t        dby_c;
	cnt_t        rem_c;
	logic        loop_c;
	cnt_t        sum_c;
	day_t        day_c;
	cnt_t        sum4_c;
	cnt_t        q7_c;
	cnt_t        wdiff_c;

	assign acc      = item.valid && item.ready;
	assign count_ok = CW'(item.day_count_in) < SPAN_DAYS;

	assign item.ready = (state_q == S_IDLE);

	// Leap days from year 1 through the year before year_q
	assign year_m1 = year_q - YW'(1);
	assign q4_c    = year_m1[YW-1:2];
	assign q100_c  = mul_p[24:17];
	assign leaps_c = q4_c - 13'(q100_c) + 13'(q100_c[7:2]);

	// Leap test on year_q: quotient by 100 and the remainder check
	assign qy_c   = mul_p[27:19];
	assign hund_c = YW'({qy_c, 6'b0}) + YW'({qy_c, 5'b0}) + YW'({qy_c, 2'b0});
	assign leap_c = (year_q[1:0] == 2'b00) && ((year_q != hund_c) || (qy_c[1:0] == 2'b00));

	assign chk_ok = (year_q >= YW'(FIRST_YEAR)) && (year_q <= YW'(LAST_YEAR)) &&
		(month_q >= 4'd1) && (month_q <= 4'd12) && (day_q != 5'd0) &&
		(day_q <= month_len(month_q, leap_q));

	assign dby_c  = mul_p[CW-1:0] + CW'(leaps_q) - CW'(FIRST_LEAPS);
	assign rem_c  = count_q - dby_c;
	assign loop_c = (year_q > YW'(FIRST_YEAR)) && (dby_c > count_q);

	assign sum_c = dby_q + CW'(cum_days(month_q, leap_q)) + CW'(day_q) - CW'(1);
	assign day_c = 5'(rem_q - cum_days(month_q, leap_q) + 9'd1);

	assign sum4_c  = count_q + CW'(4);
	assign q7_c    = CW'(mul_p[47:26]);
	assign wdiff_c = sum4_c - ((q7_c << 3) - q7_c);

	always_comb begin
		mul_req.a = '0;
		mul_req.b = '0;
		unique case (state_q)
			S_EST: begin
				mul_req.a = count_q;
				mul_req.b = RECIP_YEAR;
			end
			S_L1: begin
				mul_req.a = CW'(year_q);
				mul_req.b = RECIP_100;
			end
			S_D1: begin
				mul_req.a = CW'(q4_c);
				mul_req.b = RECIP_100;
			end
			S_D2: begin
				mul_req.a = CW'(year_q - YW'(FIRST_YEAR));
				mul_req.b = CW'(DAYS_YEAR);
			end
			S_W1: begin
				mul_req.a = sum4_c;
				mul_req.b = RECIP_7;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (item.command == CMD_COUNT) begin
						state_d = count_ok ? S_EST : S_DONE;
					end else begin
						state_d = S_L1;
					end
				end
			end
			S_EST:  state_d = S_EST2;
			S_EST2: state_d = S_D1;
			S_L1:   state_d = S_L2;
			S_L2:   state_d = (cmd_q == CMD_DATE) ? S_CHK : S_MON;
			S_CHK:  state_d = chk_ok ? S_D1 : S_DONE;
			S_D1:   state_d = S_D2;
			S_D2:   state_d = S_D3;
			S_D3: begin
				if (cmd_q == CMD_DATE) begin
					state_d = S_SUM;
				end else begin
					state_d = loop_c ? S_D1 : S_L1;
				end
			end
			S_SUM:  state_d = S_W1;
			S_MON:  state_d = S_DAY;
			S_DAY:  state_d = S_W1;
			S_W1:   state_d = S_W2;
			S_W2:   state_d = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd_q   <= item.command;
					day_q   <= item.day_in;
					month_q <= item.month_in;
					year_q  <= YW'(item.year_in);
					count_q <= CW'(item.day_count_in);
					valid_q <= (item.command == CMD_DATE) || count_ok;
				end
			end
			// Year estimate from the mean year length, never below the true year
			S_EST2: year_q <= YW'(FIRST_YEAR) + mul_p[46:32] + YW'(1);
			S_L2:   leap_q <= leap_c;
			S_CHK:  valid_q <= chk_ok;
			S_D2:   leaps_q <= leaps_c;
			S_D3: begin
				if (cmd_q == CMD_DATE) begin
					dby_q <= dby_c;
				end else if (loop_c) begin
					year_q <= year_m1;
				end else begin
					rem_q <= rem_c[8:0];
				end
			end
			S_SUM:  count_q <= sum_c;
			S_MON:  month_q <= month_of(rem_q, leap_q);
			S_DAY:  day_q <= day_c;
			S_W2:   wday_q <= wdiff_c[2:0];
			default: begin
			end
		endcase
	end

	always_comb begin
		res.valid       = (state_q == S_DONE);
		res.days_out    = valid_q ? count_q[21:0] : '0;
		res.day_out     = valid_q ? day_q : '0;
		res.month_out   = valid_q ? month_q : '0;
		res.year_out    = valid_q ? year_q[13:0] : '0;
		res.weekday_out = valid_q ? wday_q : '0;
		res.date_valid  = valid_q;
	end

endmodule

[hdl/gregorian_day_count_converter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day-count converter
// Converts day/month/year to a day count from 1 January 1970 and back, with
// range checks, weekday and a valid flag.
// ----------------------------------------------------------------------------
// One request at a time runs through a small sequencer around a single
// registered multiplier. A date-to-count request ends early when the date
// fails its check; a count-to-date request runs one or more year-correction
// passes, and an out-of-range count is rejected without any arithmetic. A
// request is taken only while the sequencer is idle. The result sits in an
// output register, so the next request can be accepted while the previous
// result waits to be taken.
module gregorian_day_count_converter_top import gdc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	gdc_in_if.sink    item,
	gdc_out_if.source result
);

	res_t     res;
	logic     res_ready;
	mul_req_t mul_req;
	prod_t    mul_p;

	logic      out_valid_q;
	count_in_t days_q;
	day_t      day_q;
	month_t    month_q;
	year_in_t  year_q;
	wday_t     wday_q;
	logic      date_valid_q;

	gdc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.res       (res),
		.res_ready (res_ready),
		.mul_req   (mul_req),
		.mul_p     (mul_p)
	);

	gdc_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p   (mul_p)
	);

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the beat only when the slot is free or being emptied
	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			days_q       <= res.days_out;
			day_q        <= res.day_out;
			month_q      <= res.month_out;
			year_q       <= res.year_out;
			wday_q       <= res.weekday_out;
			date_valid_q <= res.date_valid;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.days_out    = days_q;
	assign result.day_out     = day_q;
	assign result.month_out   = month_q;
	assign result.year_out    = year_q;
	assign result.weekday_out = wday_q;
	assign result.date_valid  = date_valid_q;

endmodule
